// ===== hdl/scfl_pkg.sv =====
// Shared types, constants and the size class table for the size class allocator.
// Used by every module of the allocator; depends on nothing.
package scfl_pkg;

  localparam int NUM_CLASSES_DEF  = 9;
  localparam int SEG_BLOCKS_DEF   = 32;
  localparam int MAX_SEGMENTS_DEF = 16;

  localparam logic [5:0] LINK_NULL = 6'd63;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  localparam logic [2:0] ST_ALLOC      = 3'd0;
  localparam logic [2:0] ST_FREED      = 3'd1;
  localparam logic [2:0] ST_NO_BLOCK   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] request_size;
    logic [3:0]  free_class;
    logic [3:0]  free_segment;
    logic [5:0]  free_slot;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] out_class;
    logic [3:0] out_segment;
    logic [4:0] out_slot;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic seg_phase;
    logic link_phase;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic early;
    logic is_free;
  } sts_t;

  function automatic logic [11:0] class_bytes(input logic [3:0] idx);
    logic [11:0] b;
    unique case (idx)
      4'd0:    b = 12'd16;
      4'd1:    b = 12'd32;
      4'd2:    b = 12'd48;
      4'd3:    b = 12'd64;
      4'd4:    b = 12'd128;
      4'd5:    b = 12'd256;
      4'd6:    b = 12'd512;
      4'd7:    b = 12'd1024;
      default: b = 12'd2048;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/scfl_ctrl.sv =====
// Sequencer of the size class allocator: clearing pass, request phases, result hand-off.
// Depends on scfl_pkg.
module scfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  scfl_pkg::sts_t    sts,
  output scfl_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SEG   = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.early ? S_FIN : S_SEG;
        end
      end
      S_SEG: begin
        cmd.seg_phase = 1'b1;
        state_nxt     = sts.is_free ? S_FIN : S_LINK;
      end
      S_LINK: begin
        cmd.link_phase = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/scfl_dp.sv =====
// Datapath of the size class allocator: link and segment memories, availability
// and growth registers, class and segment selection, result register. Depends on scfl_pkg.
module scfl_dp #(
  parameter int NUM_CLASSES  = scfl_pkg::NUM_CLASSES_DEF,
  parameter int SEG_BLOCKS   = scfl_pkg::SEG_BLOCKS_DEF,
  parameter int MAX_SEGMENTS = scfl_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scfl_pkg::in_t     in_data,
  input  scfl_pkg::cmd_t    cmd,
  output scfl_pkg::sts_t    sts,
  output scfl_pkg::out_t    out_data
);

  localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int LW  = $clog2(SEG_BLOCKS);
  localparam int SAW = CW + SW;
  localparam int LAW = SAW + LW;

  // segment record: {head, count}
  logic [11:0]   seg_mem [2**SAW];
  logic [5:0]    link_mem [2**LAW];

  logic [MAX_SEGMENTS-1:0] avail_r [NUM_CLASSES];
  logic [4:0]              built_r [NUM_CLASSES];

  logic [LAW:0]  clr_cnt_r;
  logic [LW-1:0] clr_slot;
  logic [LW:0]   clr_inc;
  logic [5:0]    clr_link;

  logic [CW-1:0] req_cls_r;
  logic [SW-1:0] req_seg_r;
  logic [LW-1:0] req_slot_r;
  logic          kind_r;
  logic [2:0]    status_r;
  logic [11:0]   seg_q_r;
  logic [5:0]    link_q_r;
  scfl_pkg::out_t out_r;
  scfl_pkg::out_t out_nxt;

  logic          found;
  logic [CW-1:0] alloc_cls;
  logic          fc_ok;
  logic [CW-1:0] cls_sel;
  logic [MAX_SEGMENTS-1:0] row;
  logic [4:0]    built;
  logic          hit;
  logic [SW-1:0] hit_seg;
  logic          can_grow;
  logic          bad;
  logic [SW-1:0] seg_sel;
  logic          grow;
  logic          early;
  logic [2:0]    early_status;
  logic [5:0]    head, count;

  assign head  = seg_q_r[11:6];
  assign count = seg_q_r[5:0];

  // first class big enough for the request
  always_comb begin
    found     = 1'b0;
    alloc_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (scfl_pkg::class_bytes(4'(i)) >= in_data.request_size) begin
        found     = 1'b1;
        alloc_cls = CW'(i);
      end
    end
  end

  assign fc_ok   = ({1'b0, in_data.free_class} < 5'(NUM_CLASSES));
  assign cls_sel = (in_data.kind == scfl_pkg::KIND_FREE) ?
                   (fc_ok ? in_data.free_class[CW-1:0] : '0) : alloc_cls;
  assign row     = avail_r[cls_sel];
  assign built   = built_r[cls_sel];

  // first built segment with a nonempty list
  always_comb begin
    hit     = 1'b0;
    hit_seg = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (row[i] && (5'(i) < built)) begin
        hit     = 1'b1;
        hit_seg = SW'(i);
      end
    end
  end

  assign can_grow = (built < 5'(MAX_SEGMENTS));
  assign bad = !fc_ok || ({1'b0, in_data.free_segment} >= built) ||
               ({1'b0, in_data.free_segment} >= 5'(MAX_SEGMENTS)) ||
               (in_data.free_slot >= 6'(SEG_BLOCKS));

  always_comb begin
    early_status = scfl_pkg::ST_ALLOC;
    early        = 1'b0;
    grow         = 1'b0;
    seg_sel      = hit_seg;
    if (in_data.kind == scfl_pkg::KIND_FREE) begin
      seg_sel = in_data.free_segment[SW-1:0];
      if (bad) begin
        early        = 1'b1;
        early_status = scfl_pkg::ST_BAD_HANDLE;
      end
    end else if (!found) begin
      early        = 1'b1;
      early_status = scfl_pkg::ST_TOO_LARGE;
    end else if (!hit) begin
      if (can_grow) begin
        grow    = 1'b1;
        seg_sel = built[SW-1:0];
      end else begin
        early        = 1'b1;
        early_status = scfl_pkg::ST_NO_BLOCK;
      end
    end
  end

  assign clr_slot = clr_cnt_r[LW-1:0];
  assign clr_inc  = {1'b0, clr_slot} + (LW+1)'(1);
  assign clr_link = (clr_inc < (LW+1)'(SEG_BLOCKS)) ? 6'(clr_inc) : scfl_pkg::LINK_NULL;

  assign sts.clear_last = (clr_cnt_r == (LAW+1)'(2**LAW - 1));
  assign sts.early      = early;
  assign sts.is_free    = kind_r;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      link_mem[clr_cnt_r[LAW-1:0]] <= clr_link;
      if (clr_slot == '0) begin
        seg_mem[clr_cnt_r[LAW-1:LW]] <= {6'd0, 6'(SEG_BLOCKS)};
      end
    end else if (cmd.seg_phase && kind_r) begin
      link_mem[{req_cls_r, req_seg_r, req_slot_r}] <= head;
      seg_mem[{req_cls_r, req_seg_r}] <=
        {6'(req_slot_r), (count == scfl_pkg::COUNT_MAX) ? count : count + 6'd1};
    end else if (cmd.link_phase) begin
      seg_mem[{req_cls_r, req_seg_r}] <= {link_q_r, count - 6'd1};
    end
    if (cmd.accept) seg_q_r <= seg_mem[{cls_sel, seg_sel}];
    if (cmd.seg_phase) link_q_r <= link_mem[{req_cls_r, req_seg_r, head[LW-1:0]}];
  end

  // handle fields stay zero unless the request allocated
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = status_r;
    if (status_r == scfl_pkg::ST_ALLOC) begin
      out_nxt.out_class   = 4'(req_cls_r);
      out_nxt.out_segment = 4'(req_seg_r);
      out_nxt.out_slot    = head[4:0];
    end
  end

  // request registers and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cls_r  <= cls_sel;
      req_seg_r  <= seg_sel;
      req_slot_r <= in_data.free_slot[LW-1:0];
      kind_r     <= in_data.kind;
      status_r   <= early ? early_status :
                    ((in_data.kind == scfl_pkg::KIND_FREE) ? scfl_pkg::ST_FREED
                                                           : scfl_pkg::ST_ALLOC);
    end
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_data = out_r;

  // control state: clearing sweep, availability, segments built
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        avail_r[c] <= '1;
        built_r[c] <= 5'd1;
      end
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + (LAW+1)'(1);
      if (cmd.accept && grow) built_r[cls_sel] <= built + 5'd1;
      if (cmd.seg_phase && kind_r) avail_r[req_cls_r][req_seg_r] <= 1'b1;
      if (cmd.link_phase) avail_r[req_cls_r][req_seg_r] <= (count != 6'd1);
    end
  end

endmodule

// ===== hdl/size_class_free_list_allocator_unit.sv =====
// Size class free list allocator, top level: joins the sequencer and the datapath.
// Depends on scfl_pkg, scfl_ctrl and scfl_dp.
//
// Usage: requests arrive on the in_ channel (valid/stall), one result per request
// leaves on the out_ channel. An allocate picks the smallest fitting size class,
// pops the head of the first nonempty built segment (building one more when all
// are empty) and returns class, segment and slot. A free checks the handle and
// pushes the slot back onto its segment list.
// After a request is accepted, an allocate passes the segment phase, the link
// phase and the finish state; a free passes the segment phase and finish; a
// rejected request goes straight to finish. The segment memory is read as the
// request is accepted, the link memory on the old head in the segment phase.
// One request is in flight at a time; the next is taken once its result is loaded.
// After reset a clearing pass writes both memories, one link entry a cycle,
// all 2**(clog2(NUM_CLASSES)+clog2(MAX_SEGMENTS)+clog2(SEG_BLOCKS)) link entries
// (8192 with defaults); in_stall stays high meanwhile.
// The result sits in an output register; while out_stall is high it holds, and
// a finished request waits for the register before the next one is taken.
module size_class_free_list_allocator_unit #(
  parameter int NUM_CLASSES  = scfl_pkg::NUM_CLASSES_DEF,
  parameter int SEG_BLOCKS   = scfl_pkg::SEG_BLOCKS_DEF,
  parameter int MAX_SEGMENTS = scfl_pkg::MAX_SEGMENTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  scfl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output scfl_pkg::out_t out_data
);

  scfl_pkg::cmd_t cmd;
  scfl_pkg::sts_t sts;

  scfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scfl_dp #(
    .NUM_CLASSES  (NUM_CLASSES),
    .SEG_BLOCKS   (SEG_BLOCKS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== hdl/scfl_checker.sv =====
// Port level checks for the size class allocator, bound to the top level.
// Depends on scfl_pkg and size_class_free_list_allocator_unit.
module scfl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input scfl_pkg::out_t out_data,
  input logic           out_valid,
  input logic           out_stall
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while a request is in flight");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != scfl_pkg::ST_ALLOC |->
      out_data.out_class == 4'd0 && out_data.out_segment == 4'd0 &&
      out_data.out_slot == 5'd0)
    else $error("handle fields set on a non-allocate result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind size_class_free_list_allocator_unit scfl_checker u_scfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
